// ----- hdl/spt_pkg.sv -----
// ============================================================================
// Sorted priority table package
// Shared widths, codes and types for the sorted priority table block.
// ============================================================================
`default_nettype none

package spt_pkg;

    // Table geometry.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Action codes carried in an input transfer.
    localparam logic [2:0] ACT_INSERT    = 3'd0;
    localparam logic [2:0] ACT_DELETE    = 3'd1;
    localparam logic [2:0] ACT_FIND_NAME = 3'd2;
    localparam logic [2:0] ACT_FIND_PRIO = 3'd3;
    localparam logic [2:0] ACT_READ      = 3'd4;

    // Status codes carried in a result transfer.
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_ZERO_PRIO = 3'd4;
    localparam logic [2:0] STAT_BAD_POS   = 3'd5;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [15:0] key_priority;
        logic        [63:0] key_name;
        logic        [4:0]  position;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [15:0] found_priority;
        logic        [63:0] found_name;
        logic        [4:0]  found_position;
        logic        [5:0]  entry_count;
    } t_out_item;

    // One stored table entry.
    typedef struct packed {
        logic signed [15:0] prio;
        logic        [63:0] name;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // latch the accepted item and set up the scan
        logic scan;   // step the table scan
        logic head;   // write the new entry at position zero
        logic emit;   // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic imm;        // the offered item is answered without a scan
        logic finish;     // the scan reached its answer this cycle
        logic exhausted;  // every entry of the scan has been handled
        logic is_insert;  // the latched item is an insert
        logic out_free;   // the output register can take a result
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/spt_ram.sv -----
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  wire logic [WIDTH-1:0]                 i_wr_data,
    input  wire logic                             i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output      logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/spt_ctrl.sv -----
// ============================================================================
// Sorted priority table controller
// Sequences one action at a time: accept, scan, head write, result.
// ============================================================================
`default_nettype none

module spt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire spt_pkg::t_stat i_stat,
    output      spt_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HEAD = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.imm ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.finish) begin
                    n_state = S_DONE;
                end else if (i_stat.exhausted) begin
                    n_state = i_stat.is_insert ? S_HEAD : S_DONE;
                end
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A head write only follows an insert scan that ran out of entries.
    a_head_after_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD) |-> ($past(r_state) == S_SCAN && $past(i_stat.is_insert)))
        else $error("head write without a preceding insert scan");

    // A new item is taken only while nothing else is in progress.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("item accepted while busy");

    // The result register is loaded only when it can take a result.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted into an occupied output register");

endmodule

`default_nettype wire

// ----- hdl/spt_dpath.sv -----
// ============================================================================
// Sorted priority table datapath
// Entry memory, scan pointers, per-action entry handling and result register.
// ============================================================================
`default_nettype none

module spt_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spt_pkg::t_cmd      i_cmd,
    input  wire spt_pkg::t_in_item  i_item,
    input  wire logic               i_out_stall,
    output      spt_pkg::t_stat     o_stat,
    output      logic               o_out_valid,
    output      spt_pkg::t_out_item o_out_item
);

    // Control state.
    logic [spt_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_pend, n_pend;
    logic                      r_out_valid;

    // Latched item and scan state.
    logic [2:0]                r_act, n_act;
    logic signed [15:0]        r_kprio, n_kprio;
    logic [63:0]               r_kname, n_kname;
    logic [spt_pkg::IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [spt_pkg::CNT_W-1:0] r_rd_left, n_rd_left;
    logic                      r_rd_down, n_rd_down;
    logic [spt_pkg::IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic                      r_hit, n_hit;
    logic [spt_pkg::IDX_W-1:0] r_first, n_first;
    logic [spt_pkg::CNT_W-1:0] r_kept, n_kept;
    spt_pkg::t_out_item        r_res, n_res;
    spt_pkg::t_out_item        r_out;
    spt_pkg::t_out_item        emit_res;

    // Memory port.
    logic                      wr_en;
    logic [spt_pkg::IDX_W-1:0] wr_addr;
    spt_pkg::t_entry           wr_data;
    logic                      issue;
    spt_pkg::t_entry           rd_data;

    logic                      imm;
    logic [2:0]                imm_status;
    logic                      proc;
    logic                      finish;
    logic                      exhausted;
    logic                      out_free;

    spt_ram #(
        .WIDTH (spt_pkg::ENTRY_W),
        .DEPTH (spt_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // Actions that are answered without a scan, from the item and the count alone.
    always_comb begin
        imm        = 1'b1;
        imm_status = spt_pkg::STAT_NOT_FOUND;
        case (i_item.action) inside
            spt_pkg::ACT_INSERT: begin
                if (i_item.key_priority == 16'sd0) begin
                    imm_status = spt_pkg::STAT_ZERO_PRIO;
                end else if (r_count == spt_pkg::CNT_W'(spt_pkg::CAPACITY)) begin
                    imm_status = spt_pkg::STAT_FULL;
                end else begin
                    imm = 1'b0;
                end
            end
            spt_pkg::ACT_DELETE, spt_pkg::ACT_FIND_NAME, spt_pkg::ACT_FIND_PRIO: begin
                if (r_count == '0) begin
                    imm_status = spt_pkg::STAT_EMPTY;
                end else begin
                    imm = 1'b0;
                end
            end
            spt_pkg::ACT_READ: begin
                if (int'(i_item.position) >= int'(r_count)) begin
                    imm_status = spt_pkg::STAT_BAD_POS;
                end else begin
                    imm = 1'b0;
                end
            end
            default: begin
                imm_status = spt_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign proc      = i_cmd.scan && r_pend;
    assign exhausted = i_cmd.scan && (r_rd_left == '0) && !r_pend;
    assign issue     = i_cmd.scan && (r_rd_left != '0);

    always_comb begin
        n_count    = r_count;
        n_act      = r_act;
        n_kprio    = r_kprio;
        n_kname    = r_kname;
        n_rd_idx   = r_rd_idx;
        n_rd_left  = r_rd_left;
        n_rd_down  = r_rd_down;
        n_pend     = issue;
        n_pend_idx = r_rd_idx;
        n_hit      = r_hit;
        n_first    = r_first;
        n_kept     = r_kept;
        n_res      = r_res;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        finish     = 1'b0;

        if (issue) begin
            n_rd_idx  = r_rd_down ? r_rd_idx - 1'b1 : r_rd_idx + 1'b1;
            n_rd_left = r_rd_left - 1'b1;
        end

        if (i_cmd.load) begin
            n_act      = i_item.action;
            n_kprio    = i_item.key_priority;
            n_kname    = i_item.key_name;
            n_pend     = 1'b0;
            n_hit      = 1'b0;
            n_first    = '0;
            n_kept     = '0;
            n_res      = '0;
            n_res.status = imm_status;
            n_rd_down  = 1'b0;
            n_rd_idx   = '0;
            n_rd_left  = r_count;
            if (i_item.action == spt_pkg::ACT_INSERT) begin
                // Inserts walk downward from the last entry, shifting as they go.
                n_rd_down = 1'b1;
                n_rd_idx  = spt_pkg::IDX_W'(r_count - 1'b1);
            end else if (i_item.action == spt_pkg::ACT_READ) begin
                n_rd_idx  = spt_pkg::IDX_W'(i_item.position);
                n_rd_left = spt_pkg::CNT_W'(1);
            end
        end

        if (proc) begin
            case (r_act)
                spt_pkg::ACT_INSERT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx + 1'b1;
                    if ($signed(rd_data.prio) >= r_kprio) begin
                        wr_data = rd_data;
                    end else begin
                        wr_data.prio = r_kprio;
                        wr_data.name = r_kname;
                        finish       = 1'b1;
                        n_count      = r_count + 1'b1;
                        n_res.status         = spt_pkg::STAT_OK;
                        n_res.found_priority = r_kprio;
                        n_res.found_name     = r_kname;
                        n_res.found_position = 5'(r_pend_idx + 1'b1);
                    end
                end
                spt_pkg::ACT_DELETE: begin
                    if (rd_data.prio == r_kprio) begin
                        if (!r_hit) begin
                            n_first = r_pend_idx;
                        end
                        n_hit = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = spt_pkg::IDX_W'(r_kept);
                        wr_data = rd_data;
                        n_kept  = r_kept + 1'b1;
                    end
                end
                default: begin
                    if ((r_act == spt_pkg::ACT_READ) ||
                        (r_act == spt_pkg::ACT_FIND_NAME && rd_data.name == r_kname) ||
                        (r_act == spt_pkg::ACT_FIND_PRIO && rd_data.prio == r_kprio)) begin
                        finish = 1'b1;
                        n_res.status         = spt_pkg::STAT_OK;
                        n_res.found_priority = rd_data.prio;
                        n_res.found_name     = rd_data.name;
                        n_res.found_position = 5'(r_pend_idx);
                    end
                end
            endcase
        end

        // End of a scan without an early answer.
        if (exhausted) begin
            if (r_act == spt_pkg::ACT_DELETE) begin
                n_count = r_kept;
                if (r_hit) begin
                    n_res.status         = spt_pkg::STAT_OK;
                    n_res.found_priority = r_kprio;
                    n_res.found_position = 5'(r_first);
                end else begin
                    n_res.status = spt_pkg::STAT_NOT_FOUND;
                end
            end else if (r_act != spt_pkg::ACT_INSERT) begin
                n_res.status = spt_pkg::STAT_NOT_FOUND;
            end
        end

        // Every stored entry was at or above the new priority.
        if (i_cmd.head) begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            wr_data.prio = r_kprio;
            wr_data.name = r_kname;
            n_count      = r_count + 1'b1;
            n_res.status         = spt_pkg::STAT_OK;
            n_res.found_priority = r_kprio;
            n_res.found_name     = r_kname;
            n_res.found_position = '0;
        end
    end

    // The finished result carries the entry count left by its action.
    always_comb begin
        emit_res             = r_res;
        emit_res.entry_count = 6'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_kprio    <= n_kprio;
        r_kname    <= n_kname;
        r_rd_idx   <= n_rd_idx;
        r_rd_left  <= n_rd_left;
        r_rd_down  <= n_rd_down;
        r_pend_idx <= n_pend_idx;
        r_hit      <= n_hit;
        r_first    <= n_first;
        r_kept     <= n_kept;
        r_res      <= n_res;
        if (i_cmd.emit) begin
            r_out <= emit_res;
        end
    end

    assign o_stat.imm       = imm;
    assign o_stat.finish    = finish;
    assign o_stat.exhausted = exhausted;
    assign o_stat.is_insert = (r_act == spt_pkg::ACT_INSERT);
    assign o_stat.out_free  = out_free;
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= spt_pkg::CAPACITY)
        else $error("entry count above capacity");

    // Memory writes happen only while scanning or placing a head entry.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (i_cmd.scan || i_cmd.head))
        else $error("table write outside a scan");

    // A head write grows the table by exactly one entry.
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.head |=> (r_count == $past(r_count) + spt_pkg::CNT_W'(1)))
        else $error("head insert did not grow the table");

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_table_top.sv -----
// ============================================================================
// Sorted priority table
// Fixed-capacity table of priority and name entries kept in ascending order.
// ============================================================================
// Usage: the input channel carries one action per transfer (insert, delete
// by priority, find by name, find by priority or read at a position) and the
// output channel returns exactly one result transfer for each of them. Both
// channels use valid and stall; a transfer completes on a clock edge with
// valid high and stall low.
// Sequencing: one action is in progress at a time. Actions that are
// answered without a scan, from the item and the entry count (zero-priority
// or full insert, empty table, bad read position, unknown action), go straight
// to the result. Other actions scan the entry memory one entry per cycle
// through its single read port; a read fetches only its one entry. An insert
// in front of every stored entry needs an extra head write after its scan.
// The input side is stalled while an action is in progress and is released
// as soon as its result is in the output register, so the next transfer can
// be taken while that result still waits for the receiver.
// Reset (synchronous, active low) empties the table; the entry memory itself
// is not cleared. A stall from the receiver holds the result and keeps the
// block from finishing the following action until the register is freed.
// ============================================================================
`default_nettype none

module sorted_priority_table_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire spt_pkg::t_in_item  i_in_item,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      spt_pkg::t_out_item o_out_item
);

    // Command and status groups between the sequencer and the datapath.
    spt_pkg::t_cmd  cmd;
    spt_pkg::t_stat stat;

    // The controller owns the input handshake and steps the datapath
    // through load, scan, head write and result hand-off.
    spt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the entry memory, the count and the result register.
    spt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
